[hdl/prq_pkg.sv]
// Package for the ready-queue scheduler: field widths, request and status codes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package prq_pkg;

  localparam int PRIO_COUNT_DEF = 32;
  localparam int TASK_COUNT_DEF = 64;

  localparam int KIND_W    = 2;
  localparam int TASK_ID_W = 6;
  localparam int PRIO_W    = 5;
  localparam int STATUS_W  = 2;

  localparam logic [KIND_W-1:0] KIND_READY     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOT_READY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRIO      = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WRONG    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RESERVED = 2'd2;

  typedef struct packed {
    logic                take;
    logic                rd1;
    logic                rd2;
    logic                append;
    logic                unlink;
    logic                set_level;
    logic                rd_app;
    logic                scan;
    logic                pick;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } prq_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [KIND_W-1:0] kind;
    logic              bad;
    logic              task_rdy;
    logic              task_idle;
    logic              np_reserved;
    logic              emptied;
    logic              out_free;
  } prq_sts_t;

endpackage

[hdl/prq_in_if.sv]
// Request channel: valid/ready handshake with the request fields.
// Depends on prq_pkg.
interface prq_in_if
  import prq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [TASK_ID_W-1:0] task_id;
  logic [PRIO_W-1:0]    new_level;

  modport source (output valid, kind, task_id, new_level, input ready);
  modport sink (input valid, kind, task_id, new_level, output ready);
endinterface

[hdl/prq_out_if.sv]
// Result channel: valid/ready handshake with next task and status.
// Depends on prq_pkg.
interface prq_out_if
  import prq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [TASK_ID_W-1:0] next_task;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, next_task, status, input ready);
  modport sink (input valid, next_task, status, output ready);
endinterface

[hdl/prq_ctrl.sv]
// Sequencer for the scheduler: walks each request through its read, update,
// rescan and reply steps. Depends on prq_pkg.
module prq_ctrl
  import prq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  prq_sts_t sts,
  output prq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD1, S_RD2, S_EXEC, S_RDAPP, S_APP, S_SCAN, S_PICK, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          state_nxt  = S_CHECK;
          status_nxt = STATUS_DONE;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          status_nxt = STATUS_WRONG;
          state_nxt  = S_FIN;
        end else begin
          case (sts.kind)
            KIND_READY: begin
              if (sts.task_rdy) begin
                status_nxt = STATUS_WRONG;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_RD1;
              end
            end
            KIND_NOT_READY: begin
              if (sts.task_idle || !sts.task_rdy) begin
                status_nxt = STATUS_WRONG;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_RD1;
              end
            end
            default: begin
              if (sts.np_reserved) begin
                status_nxt = STATUS_RESERVED;
                state_nxt  = S_FIN;
              end else if (!sts.task_rdy) begin
                cmd.set_level = 1'b1;
                state_nxt     = S_FIN;
              end else begin
                state_nxt = S_RD1;
              end
            end
          endcase
        end
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (sts.kind)
          KIND_READY: begin
            cmd.append = 1'b1;
            state_nxt  = S_FIN;
          end
          KIND_NOT_READY: begin
            cmd.unlink = 1'b1;
            state_nxt  = sts.emptied ? S_SCAN : S_FIN;
          end
          default: begin
            cmd.unlink    = 1'b1;
            cmd.set_level = 1'b1;
            state_nxt     = S_RDAPP;
          end
        endcase
      end
      S_RDAPP: begin
        cmd.rd_app = 1'b1;
        state_nxt  = S_APP;
      end
      S_APP: begin
        cmd.append = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= STATUS_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

[hdl/prq_dpath.sv]
// Scheduler datapath: link, level, head and tail stores, ready bitmap,
// chosen task and the result register. Depends on prq_pkg and the channel interfaces.
module prq_dpath
  import prq_pkg::*;
#(
  parameter int PRIORITY_COUNT = PRIO_COUNT_DEF,
  parameter int TASK_COUNT     = TASK_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  prq_in_if.sink    in_ch,
  prq_out_if.source out_ch,
  input  prq_cmd_t  cmd,
  output prq_sts_t  sts
);

  localparam int LW = $clog2(PRIORITY_COUNT);
  localparam int TW = $clog2(TASK_COUNT);
  localparam logic [LW-1:0] LOWEST = LW'(PRIORITY_COUNT - 1);

  // request
  logic [KIND_W-1:0] kind_r;
  logic [TW-1:0]     t_r;
  logic [PRIO_W-1:0] np_r;
  logic              range_ok_r;

  // stores
  logic [TW-1:0] lnext_mem [TASK_COUNT];
  logic [TW-1:0] lprev_mem [TASK_COUNT];
  logic [LW-1:0] lvl_mem   [TASK_COUNT];
  logic [TW-1:0] head_mem  [PRIORITY_COUNT];
  logic [TW-1:0] tail_mem  [PRIORITY_COUNT];
  logic [TASK_COUNT-1:0]     lvl_vld_r, ready_r, ready_nxt;
  logic [PRIORITY_COUNT-1:0] head_vld_r, tail_vld_r, bitmap_r, bitmap_nxt;
  logic [TW-1:0] chosen_r, chosen_nxt;
  logic [LW-1:0] chosen_lvl_r, chosen_lvl_nxt;

  // read data
  logic [LW-1:0] lvl_q, scan_lvl_q;
  logic          lvl_vq, head_vq, tail_vq, scan_empty_q;
  logic [TW-1:0] nx_q, pv_q, head_q, tail_q;

  // result
  logic                 out_valid_r;
  logic [TASK_ID_W-1:0] out_task_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic [LW-1:0] lv, np_lv, app_lv, hd_ra, tl_ra, hd_wa, tl_wa;
  logic [TW-1:0] head_eff, tail_eff, hd_wd, ln_wa, ln_wd, lp_wa, lp_wd;
  logic          hd_we, tl_we, ln_we, lp_we, is_head, is_tail;
  logic [LW:0]   ffs_res;

  function automatic logic [LW:0] ffs(input logic [PRIORITY_COUNT-1:0] v);
    logic [LW:0] r;
    r = '0;
    for (int i = PRIORITY_COUNT - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, LW'(i)};
    end
    return r;
  endfunction

  assign lv       = lvl_vq ? lvl_q : LOWEST;
  assign np_lv    = LW'(np_r);
  assign app_lv   = (kind_r == KIND_PRIO) ? np_lv : lv;
  assign head_eff = head_vq ? head_q : '0;
  assign tail_eff = tail_vq ? tail_q : '0;
  assign is_head  = (head_eff == t_r);
  assign is_tail  = (tail_eff == t_r);
  assign ffs_res  = ffs(bitmap_r);
  assign hd_ra    = cmd.scan ? ffs_res[LW-1:0] : lv;
  assign tl_ra    = cmd.rd_app ? np_lv : lv;

  assign sts.in_valid    = in_ch.valid;
  assign sts.kind        = kind_r;
  assign sts.bad         = !range_ok_r || (kind_r != KIND_READY && kind_r != KIND_NOT_READY
                                           && kind_r != KIND_PRIO);
  assign sts.task_rdy    = ready_r[t_r];
  assign sts.task_idle   = (t_r == '0);
  assign sts.np_reserved = (32'(np_r) >= 32'(PRIORITY_COUNT - 1));
  assign sts.emptied     = is_head && is_tail;
  assign sts.out_free    = !out_valid_r || out_ch.ready;

  // no request is taken while reset is held
  assign in_ch.ready      = cmd.take && rst_n;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_task = out_task_r;
  assign out_ch.status    = out_status_r;

  // queue updates
  always_comb begin
    hd_we = 1'b0; hd_wa = app_lv; hd_wd = t_r;
    tl_we = 1'b0; tl_wa = app_lv;
    ln_we = 1'b0; ln_wa = tail_eff; ln_wd = t_r;
    lp_we = 1'b0; lp_wa = t_r;      lp_wd = tail_eff;
    bitmap_nxt     = bitmap_r;
    ready_nxt      = ready_r;
    chosen_nxt     = chosen_r;
    chosen_lvl_nxt = chosen_lvl_r;
    if (cmd.append) begin
      if (!bitmap_r[app_lv]) begin
        hd_we = 1'b1;
      end else begin
        ln_we = 1'b1;
        lp_we = 1'b1;
      end
      tl_we              = 1'b1;
      bitmap_nxt[app_lv] = 1'b1;
      ready_nxt[t_r]     = 1'b1;
      if (kind_r == KIND_READY && lv < chosen_lvl_r) begin
        chosen_nxt     = t_r;
        chosen_lvl_nxt = lv;
      end
    end
    if (cmd.unlink) begin
      hd_wa = lv; hd_wd = nx_q;
      tl_wa = lv;
      ln_wa = pv_q; ln_wd = nx_q;
      lp_wa = nx_q; lp_wd = pv_q;
      if (kind_r == KIND_NOT_READY) ready_nxt[t_r] = 1'b0;
      if (is_head && is_tail) begin
        bitmap_nxt[lv] = 1'b0;
      end else begin
        if (is_head) hd_we = 1'b1;
        else         ln_we = 1'b1;
        if (is_tail) tl_we = 1'b1;
        else         lp_we = 1'b1;
        if (kind_r == KIND_NOT_READY && chosen_r == t_r) begin
          chosen_nxt     = is_head ? nx_q : head_eff;
          chosen_lvl_nxt = lv;
        end
      end
    end
    if (cmd.pick) begin
      chosen_nxt     = scan_empty_q ? '0 : head_eff;
      chosen_lvl_nxt = scan_lvl_q;
    end
  end

  // tail write data is always the request task, or the predecessor on unlink
  always_ff @(posedge clk) begin
    if (tl_we) tail_mem[tl_wa] <= cmd.unlink ? pv_q : t_r;
    if (cmd.rd2 || cmd.rd_app) tail_q <= tail_mem[tl_ra];
    if (cmd.rd2 || cmd.rd_app) tail_vq <= tail_vld_r[tl_ra];
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (cmd.rd2 || cmd.scan) begin
      head_q  <= head_mem[hd_ra];
      head_vq <= head_vld_r[hd_ra];
    end
    if (cmd.scan) begin
      scan_lvl_q   <= ffs_res[LW-1:0];
      scan_empty_q <= !ffs_res[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (ln_we) lnext_mem[ln_wa] <= ln_wd;
    if (cmd.rd1) nx_q <= lnext_mem[t_r];
  end

  always_ff @(posedge clk) begin
    if (lp_we) lprev_mem[lp_wa] <= lp_wd;
    if (cmd.rd1) pv_q <= lprev_mem[t_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.set_level) lvl_mem[t_r] <= np_lv;
    if (cmd.rd1) begin
      lvl_q  <= lvl_mem[t_r];
      lvl_vq <= lvl_vld_r[t_r];
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.take) begin
      kind_r     <= in_ch.kind;
      t_r        <= TW'(in_ch.task_id);
      np_r       <= in_ch.new_level;
      range_ok_r <= (32'(in_ch.task_id) < 32'(TASK_COUNT));
    end
    if (cmd.finish) begin
      out_task_r   <= TASK_ID_W'(chosen_r);
      out_status_r <= cmd.status;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_vld_r    <= '0;
      head_vld_r   <= '0;
      tail_vld_r   <= '0;
      bitmap_r     <= {1'b1, {(PRIORITY_COUNT - 1){1'b0}}};
      ready_r      <= {{(TASK_COUNT - 1){1'b0}}, 1'b1};
      chosen_r     <= '0;
      chosen_lvl_r <= LOWEST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.set_level) lvl_vld_r[t_r] <= 1'b1;
      if (hd_we) head_vld_r[hd_wa] <= 1'b1;
      if (tl_we) tail_vld_r[tl_wa] <= 1'b1;
      bitmap_r     <= bitmap_nxt;
      ready_r      <= ready_nxt;
      chosen_r     <= chosen_nxt;
      chosen_lvl_r <= chosen_lvl_nxt;
      if (cmd.finish)        out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

endmodule

[hdl/priority_ready_queue_scheduler.sv]
// Ready-queue scheduler top level: sequencer plus datapath.
// Depends on prq_pkg, prq_in_if, prq_out_if, prq_ctrl and prq_dpath.
//
// Keeps one FIFO of task numbers per priority level (lower is more urgent)
// as doubly linked lists in per-task link stores, with a head and tail per
// level, a ready bitmap and the task chosen to run next. Each request word
// makes a task ready, makes it not ready, or changes its priority, and
// yields exactly one result word: the task chosen next and a status code
// (done, wrong state, level reserved for idle). Task 0 is the idle task and
// sits alone at the lowest level after reset. Requests are handled one at a
// time; the cost is set by the single-port link, level, head and tail
// stores, each read through a registered port. A rejected request or a level
// change of a task that is not ready goes straight to the reply; make ready
// and make not ready read the link, level, head and tail stores and then
// append or unlink, adding a find-first-set rescan and head read when
// removal empties a queue; a level change that moves a ready task unlinks
// it, reads the tail at the new level, appends and rescans. A finished
// result sits in an output register; the block waits only if that register
// is still held. No clearing pass is needed after reset.
module priority_ready_queue_scheduler
  import prq_pkg::*;
#(
  parameter int PRIORITY_COUNT = PRIO_COUNT_DEF,
  parameter int TASK_COUNT     = TASK_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  prq_in_if.sink    in_ch,
  prq_out_if.source out_ch
);

  prq_cmd_t cmd;
  prq_sts_t sts;

  prq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  prq_dpath #(
    .PRIORITY_COUNT (PRIORITY_COUNT),
    .TASK_COUNT     (TASK_COUNT)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
